[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in a cycle -> b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// a holds in a cycle -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

[rtl/core/c65_pkg.sv]
`default_nettype none
package c65_pkg;

   localparam logic [5:0] OP_ADC = 6'd0;
   localparam logic [5:0] OP_AND = 6'd1;
   localparam logic [5:0] OP_ASL = 6'd2;
   localparam logic [5:0] OP_BCC = 6'd3;
   localparam logic [5:0] OP_BCS = 6'd4;
   localparam logic [5:0] OP_BEQ = 6'd5;
   localparam logic [5:0] OP_BIT = 6'd6;
   localparam logic [5:0] OP_BMI = 6'd7;
   localparam logic [5:0] OP_BNE = 6'd8;
   localparam logic [5:0] OP_BPL = 6'd9;
   localparam logic [5:0] OP_BRK = 6'd10;
   localparam logic [5:0] OP_BVC = 6'd11;
   localparam logic [5:0] OP_BVS = 6'd12;
   localparam logic [5:0] OP_CLC = 6'd13;
   localparam logic [5:0] OP_CLD = 6'd14;
   localparam logic [5:0] OP_CLI = 6'd15;
   localparam logic [5:0] OP_CLV = 6'd16;
   localparam logic [5:0] OP_CMP = 6'd17;
   localparam logic [5:0] OP_CPX = 6'd18;
   localparam logic [5:0] OP_CPY = 6'd19;
   localparam logic [5:0] OP_DEC = 6'd20;
   localparam logic [5:0] OP_DEX = 6'd21;
   localparam logic [5:0] OP_DEY = 6'd22;
   localparam logic [5:0] OP_EOR = 6'd23;
   localparam logic [5:0] OP_INC = 6'd24;
   localparam logic [5:0] OP_INX = 6'd25;
   localparam logic [5:0] OP_INY = 6'd26;
   localparam logic [5:0] OP_JMP = 6'd27;
   localparam logic [5:0] OP_JSR = 6'd28;
   localparam logic [5:0] OP_LDA = 6'd29;
   localparam logic [5:0] OP_LDX = 6'd30;
   localparam logic [5:0] OP_LDY = 6'd31;
   localparam logic [5:0] OP_LSR = 6'd32;
   localparam logic [5:0] OP_ORA = 6'd34;
   localparam logic [5:0] OP_PHA = 6'd35;
   localparam logic [5:0] OP_PHP = 6'd36;
   localparam logic [5:0] OP_PLA = 6'd37;
   localparam logic [5:0] OP_PLP = 6'd38;
   localparam logic [5:0] OP_ROL = 6'd39;
   localparam logic [5:0] OP_ROR = 6'd40;
   localparam logic [5:0] OP_RTI = 6'd41;
   localparam logic [5:0] OP_RTS = 6'd42;
   localparam logic [5:0] OP_SBC = 6'd43;
   localparam logic [5:0] OP_SEC = 6'd44;
   localparam logic [5:0] OP_SED = 6'd45;
   localparam logic [5:0] OP_SEI = 6'd46;
   localparam logic [5:0] OP_STA = 6'd47;
   localparam logic [5:0] OP_STX = 6'd48;
   localparam logic [5:0] OP_STY = 6'd49;
   localparam logic [5:0] OP_TAX = 6'd50;
   localparam logic [5:0] OP_TAY = 6'd51;
   localparam logic [5:0] OP_TSX = 6'd52;
   localparam logic [5:0] OP_TXA = 6'd53;
   localparam logic [5:0] OP_TXS = 6'd54;
   localparam logic [5:0] OP_TYA = 6'd55;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET    = 8'hFD;

   typedef struct packed {
      logic [15:0] last_byte_address;
      logic [15:0] target_address;
      logic        on_accumulator;
      logic [7:0]  operand;
      logic [5:0]  opcode;
   } item_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] p;
      logic [7:0] sp;
   } regs_type;

   typedef struct packed {
      logic [1:0] push_cnt;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } stack_ctl_type;

   typedef struct packed {
      logic [7:0] r1;
      logic [7:0] r2;
      logic [7:0] r3;
   } stack_rd_type;

endpackage
`default_nettype wire

[rtl/core/c65_stack.sv]
`default_nettype none
module c65_stack (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [7:0]             sp,
   input  wire logic [7:0]             rd_sp,
   input  wire c65_pkg::stack_ctl_type ctl,
   output logic                        busy,
   output c65_pkg::stack_rd_type       rd
);

   // Four banks on sp[1:0]: the three bytes a push or pull touches are
   // consecutive, so each bank sees at most one write and one read a cycle.
   logic       clr_busy_ff, clr_busy_in;
   logic [5:0] clr_row_ff, clr_row_in;
   logic [1:0] rsel_ff;
   logic [7:0] rq [4];

   assign busy        = clr_busy_ff;
   assign clr_busy_in = clr_busy_ff && (clr_row_ff != 6'd63);
   assign clr_row_in  = clr_row_ff + 6'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   always_ff @(posedge clock) begin
      rsel_ff <= rd_sp[1:0];
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      logic [7:0] mem_ff [64];
      logic [7:0] q_ff;
      logic [1:0] wk, rk;
      logic [7:0] waddr, raddr, wdat;
      logic [5:0] wrow;
      logic       we;

      assign wk    = sp[1:0] - 2'(g);
      assign waddr = sp - {6'd0, wk};
      assign rk    = 2'(g) - rd_sp[1:0] - 2'd1;
      assign raddr = rd_sp + 8'd1 + {6'd0, rk};

      always_comb begin
         if (clr_busy_ff) begin
            we   = 1'b1;
            wrow = clr_row_ff;
            wdat = 8'h00;
         end else begin
            we   = wr_en && (wk < ctl.push_cnt);
            wrow = waddr[7:2];
            unique case (wk)
               2'd0:    wdat = ctl.b0;
               2'd1:    wdat = ctl.b1;
               2'd2:    wdat = ctl.b2;
               default: wdat = 8'h00;
            endcase
         end
      end

      // read for the sp of the next cycle, bypassing this cycle's write
      always_ff @(posedge clock) begin
         if (!reset && we) mem_ff[wrow] <= wdat;
         if (!reset && we && wrow == raddr[7:2]) q_ff <= wdat;
         else q_ff <= mem_ff[raddr[7:2]];
      end

      assign rq[g] = q_ff;
   end

   always_comb begin
      rd.r1 = rq[rsel_ff + 2'd1];
      rd.r2 = rq[rsel_ff + 2'd2];
      rd.r3 = rq[rsel_ff + 2'd3];
   end

endmodule
`default_nettype wire

[rtl/core/c65_exec.sv]
`default_nettype none
module c65_exec (
   input  wire c65_pkg::item_type       item,
   input  wire c65_pkg::regs_type       cur,
   input  wire c65_pkg::stack_rd_type   rd,
   output c65_pkg::regs_type            nxt,
   output c65_pkg::stack_ctl_type       ctl,
   output logic [15:0]                  next_pc,
   output logic [7:0]                   write_data,
   output logic                         write_enable
);

   logic [7:0]  m, src, res, pushed_p;
   logic [8:0]  sum;
   logic [15:0] seq_pc, brk_pc;
   logic        taken, rmw, do_add;
   logic [7:0]  add_m, cmp_reg, nz_v;
   logic        nz_en;

   assign m        = item.operand;
   assign src      = item.on_accumulator ? cur.acc : m;
   assign seq_pc   = item.last_byte_address + 16'd1;
   assign brk_pc   = seq_pc;
   assign pushed_p = cur.p | 8'h30;
   assign add_m    = (item.opcode == c65_pkg::OP_SBC) ? ~m : m;
   assign sum      = {1'b0, cur.acc} + {1'b0, add_m} + {8'd0, cur.p[c65_pkg::FLAG_C]};

   always_comb begin
      nxt          = cur;
      ctl          = '0;
      next_pc      = seq_pc;
      write_data   = 8'h00;
      write_enable = 1'b0;
      taken        = 1'b0;
      rmw          = 1'b0;
      res          = 8'h00;
      do_add       = 1'b0;
      cmp_reg      = cur.acc;
      nz_v         = 8'h00;
      nz_en        = 1'b0;
      unique case (item.opcode)
         c65_pkg::OP_ADC, c65_pkg::OP_SBC: do_add = 1'b1;
         c65_pkg::OP_AND: begin nxt.acc = cur.acc & m; nz_v = nxt.acc; nz_en = 1'b1; end
         c65_pkg::OP_ORA: begin nxt.acc = cur.acc | m; nz_v = nxt.acc; nz_en = 1'b1; end
         c65_pkg::OP_EOR: begin nxt.acc = cur.acc ^ m; nz_v = nxt.acc; nz_en = 1'b1; end
         c65_pkg::OP_ASL: begin
            nxt.p[c65_pkg::FLAG_C] = src[7];
            res = {src[6:0], 1'b0}; rmw = 1'b1;
         end
         c65_pkg::OP_LSR: begin
            nxt.p[c65_pkg::FLAG_C] = src[0];
            res = {1'b0, src[7:1]}; rmw = 1'b1;
         end
         c65_pkg::OP_ROL: begin
            nxt.p[c65_pkg::FLAG_C] = src[7];
            res = {src[6:0], cur.p[c65_pkg::FLAG_C]}; rmw = 1'b1;
         end
         c65_pkg::OP_ROR: begin
            nxt.p[c65_pkg::FLAG_C] = src[0];
            res = {cur.p[c65_pkg::FLAG_C], src[7:1]}; rmw = 1'b1;
         end
         c65_pkg::OP_DEC: begin res = src - 8'd1; rmw = 1'b1; end
         c65_pkg::OP_INC: begin res = src + 8'd1; rmw = 1'b1; end
         c65_pkg::OP_BCC: taken = !cur.p[c65_pkg::FLAG_C];
         c65_pkg::OP_BCS: taken = cur.p[c65_pkg::FLAG_C];
         c65_pkg::OP_BEQ: taken = cur.p[c65_pkg::FLAG_Z];
         c65_pkg::OP_BNE: taken = !cur.p[c65_pkg::FLAG_Z];
         c65_pkg::OP_BMI: taken = cur.p[c65_pkg::FLAG_N];
         c65_pkg::OP_BPL: taken = !cur.p[c65_pkg::FLAG_N];
         c65_pkg::OP_BVC: taken = !cur.p[c65_pkg::FLAG_V];
         c65_pkg::OP_BVS: taken = cur.p[c65_pkg::FLAG_V];
         c65_pkg::OP_BIT: begin
            nxt.p[c65_pkg::FLAG_Z] = (cur.acc & m) == 8'h00;
            nxt.p[c65_pkg::FLAG_N] = m[7];
            nxt.p[c65_pkg::FLAG_V] = m[6];
         end
         c65_pkg::OP_BRK: begin
            ctl.push_cnt = 2'd3;
            ctl.b0 = brk_pc[15:8];
            ctl.b1 = brk_pc[7:0];
            ctl.b2 = pushed_p;
            nxt.sp = cur.sp - 8'd3;
            nxt.p[c65_pkg::FLAG_I] = 1'b1;
            next_pc = item.target_address;
         end
         c65_pkg::OP_CLC: nxt.p[c65_pkg::FLAG_C] = 1'b0;
         c65_pkg::OP_CLD: nxt.p[c65_pkg::FLAG_D] = 1'b0;
         c65_pkg::OP_CLI: nxt.p[c65_pkg::FLAG_I] = 1'b0;
         c65_pkg::OP_CLV: nxt.p[c65_pkg::FLAG_V] = 1'b0;
         c65_pkg::OP_SEC: nxt.p[c65_pkg::FLAG_C] = 1'b1;
         c65_pkg::OP_SED: nxt.p[c65_pkg::FLAG_D] = 1'b1;
         c65_pkg::OP_SEI: nxt.p[c65_pkg::FLAG_I] = 1'b1;
         c65_pkg::OP_CMP, c65_pkg::OP_CPX, c65_pkg::OP_CPY: begin
            if (item.opcode == c65_pkg::OP_CPX) cmp_reg = cur.x;
            else if (item.opcode == c65_pkg::OP_CPY) cmp_reg = cur.y;
            else cmp_reg = cur.acc;
            nxt.p[c65_pkg::FLAG_C] = cmp_reg >= m;
            nz_v = cmp_reg - m; nz_en = 1'b1;
         end
         c65_pkg::OP_DEX: begin nxt.x = cur.x - 8'd1; nz_v = nxt.x; nz_en = 1'b1; end
         c65_pkg::OP_DEY: begin nxt.y = cur.y - 8'd1; nz_v = nxt.y; nz_en = 1'b1; end
         c65_pkg::OP_INX: begin nxt.x = cur.x + 8'd1; nz_v = nxt.x; nz_en = 1'b1; end
         c65_pkg::OP_INY: begin nxt.y = cur.y + 8'd1; nz_v = nxt.y; nz_en = 1'b1; end
         c65_pkg::OP_JMP: next_pc = item.target_address;
         c65_pkg::OP_JSR: begin
            ctl.push_cnt = 2'd2;
            ctl.b0 = item.last_byte_address[15:8];
            ctl.b1 = item.last_byte_address[7:0];
            nxt.sp = cur.sp - 8'd2;
            next_pc = item.target_address;
         end
         c65_pkg::OP_LDA: begin nxt.acc = m; nz_v = m; nz_en = 1'b1; end
         c65_pkg::OP_LDX: begin nxt.x = m; nz_v = m; nz_en = 1'b1; end
         c65_pkg::OP_LDY: begin nxt.y = m; nz_v = m; nz_en = 1'b1; end
         c65_pkg::OP_PHA: begin
            ctl.push_cnt = 2'd1; ctl.b0 = cur.acc; nxt.sp = cur.sp - 8'd1;
         end
         c65_pkg::OP_PHP: begin
            ctl.push_cnt = 2'd1; ctl.b0 = pushed_p; nxt.sp = cur.sp - 8'd1;
         end
         c65_pkg::OP_PLA: begin
            nxt.acc = rd.r1; nz_v = rd.r1; nz_en = 1'b1; nxt.sp = cur.sp + 8'd1;
         end
         c65_pkg::OP_PLP: begin
            nxt.p = (rd.r1 & 8'hEF) | 8'h20; nxt.sp = cur.sp + 8'd1;
         end
         c65_pkg::OP_RTI: begin
            nxt.p = (rd.r1 & 8'hEF) | 8'h20;
            next_pc = {rd.r3, rd.r2};
            nxt.sp = cur.sp + 8'd3;
         end
         c65_pkg::OP_RTS: begin
            next_pc = {rd.r2, rd.r1} + 16'd1;
            nxt.sp = cur.sp + 8'd2;
         end
         c65_pkg::OP_STA: begin write_data = cur.acc; write_enable = 1'b1; end
         c65_pkg::OP_STX: begin write_data = cur.x; write_enable = 1'b1; end
         c65_pkg::OP_STY: begin write_data = cur.y; write_enable = 1'b1; end
         c65_pkg::OP_TAX: begin nxt.x = cur.acc; nz_v = cur.acc; nz_en = 1'b1; end
         c65_pkg::OP_TAY: begin nxt.y = cur.acc; nz_v = cur.acc; nz_en = 1'b1; end
         c65_pkg::OP_TSX: begin nxt.x = cur.sp; nz_v = cur.sp; nz_en = 1'b1; end
         c65_pkg::OP_TXA: begin nxt.acc = cur.x; nz_v = cur.x; nz_en = 1'b1; end
         c65_pkg::OP_TXS: nxt.sp = cur.x;
         c65_pkg::OP_TYA: begin nxt.acc = cur.y; nz_v = cur.y; nz_en = 1'b1; end
         default: ;
      endcase

      if (do_add) begin
         nxt.acc = sum[7:0];
         nxt.p[c65_pkg::FLAG_C] = sum[8];
         nxt.p[c65_pkg::FLAG_V] = ~(cur.acc[7] ^ add_m[7]) & (cur.acc[7] ^ sum[7]);
         nz_v = sum[7:0]; nz_en = 1'b1;
      end
      if (rmw) begin
         nz_v = res; nz_en = 1'b1;
         if (item.on_accumulator) begin
            nxt.acc = res;
         end else begin
            write_data = res; write_enable = 1'b1;
         end
      end
      if (nz_en) begin
         nxt.p[c65_pkg::FLAG_N] = nz_v[7];
         nxt.p[c65_pkg::FLAG_Z] = nz_v == 8'h00;
      end
      if (taken) begin
         next_pc = seq_pc + {{8{m[7]}}, m};
      end
   end

endmodule
`default_nettype wire

[rtl/core/cpu6502_execute_unit.sv]
// Channel  Dir  Payload
// req      in   tdata: opcode, operand, target_address, last_byte_address; tuser: on_accumulator
// rsp      out  tdata: next_pc, write_data, acc/x/y/flags/sp; tuser: write_enable
//
// One instruction per cycle unless rsp stalls: input register, one pass of decode/ALU logic,
// result register, which drives rsp_tvalid.
// Stack: four 64-entry banks with registered reads, fetched for the next sp with write bypass.
// After reset a pass over all 64 rows clears the stack; req_tready stays low meanwhile.
// Synchronous reset; a stalled rsp holds the pipe, req keeps flowing while a slot is free.
`default_nettype none
`include "assert_macros.svh"
module cpu6502_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // opcode, operand, target_address, last_byte_address, pad
   input  wire logic        req_tuser,  // on_accumulator
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // next_pc, write_data, acc, x, y, flags, sp
   output logic             rsp_tuser   // write_enable
);

   c65_pkg::item_type      item_ff, item_in;
   c65_pkg::regs_type      regs_ff, regs_in, regs_nxt;
   c65_pkg::stack_ctl_type ctl;
   c65_pkg::stack_rd_type  rd;
   logic        in_v_ff, in_v_in, out_v_ff, out_v_in, advance, exec_go;
   logic [63:0] data_ff, data_in;
   logic        wen_ff, wen_in;
   logic [15:0] next_pc;
   logic [7:0]  wdata;
   logic        wen;
   logic        stack_busy;

   assign advance    = !out_v_ff || rsp_tready;
   assign exec_go    = advance && in_v_ff;
   assign req_tready = !stack_busy && (!in_v_ff || advance);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = wen_ff;

   always_comb begin
      item_in.opcode            = req_tdata[5:0];
      item_in.operand           = req_tdata[13:6];
      item_in.on_accumulator    = req_tuser;
      item_in.target_address    = req_tdata[29:14];
      item_in.last_byte_address = req_tdata[45:30];
      if (req_tvalid && req_tready) in_v_in = 1'b1;
      else if (advance) in_v_in = 1'b0;
      else in_v_in = in_v_ff;
      out_v_in = advance ? in_v_ff : out_v_ff;
      regs_in  = exec_go ? regs_nxt : regs_ff;
      data_in  = {regs_nxt.sp, regs_nxt.p, regs_nxt.y, regs_nxt.x, regs_nxt.acc, wdata, next_pc};
      wen_in   = wen;
   end

   c65_exec u_exec (
      .item(item_ff), .cur(regs_ff), .rd(rd), .nxt(regs_nxt), .ctl(ctl),
      .next_pc(next_pc), .write_data(wdata), .write_enable(wen)
   );

   c65_stack u_stack (
      .clock(clock), .reset(reset), .wr_en(exec_go), .sp(regs_ff.sp), .rd_sp(regs_in.sp),
      .ctl(ctl), .busy(stack_busy), .rd(rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         regs_ff  <= '{acc: 8'h00, x: 8'h00, y: 8'h00,
                       p: c65_pkg::FLAGS_RESET, sp: c65_pkg::SP_RESET};
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         regs_ff  <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) item_ff <= item_in;
      if (exec_go) begin
         data_ff <= data_in;
         wen_ff  <= wen_in;
      end
   end

   `ASSERT_IMPLIES(a_flag_u_set, clock, reset, 1'b1, regs_ff.p[c65_pkg::FLAG_U])
   `ASSERT_IMPLIES(a_flag_b_clr, clock, reset, 1'b1, !regs_ff.p[c65_pkg::FLAG_B])
   `ASSERT_NEXT(a_regs_hold, clock, !reset && !exec_go, $stable(regs_ff) || reset)
   `ASSERT_NEXT(a_reset_regs, clock, reset, regs_ff.sp == c65_pkg::SP_RESET && !rsp_tvalid)

endmodule
`default_nettype wire
